@@ hw/rtl/otsa_pkg.sv @@
`default_nettype none

package otsa_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned OP_W   = 3;
  localparam int unsigned ST_W   = 3;
  localparam int unsigned FLAG_W = 3;
  localparam int unsigned CFG_W  = 7;

  // Live slot count after reset
  localparam logic [CFG_W-1:0] ENTRIES_RESET = 7'd64;

  // Update flag bit positions
  localparam int unsigned FLAG_NOEXIST = 0;
  localparam int unsigned FLAG_EXIST   = 1;

  typedef enum logic [OP_W-1:0] {
    OP_LOOKUP   = 3'd0,
    OP_UPDATE   = 3'd1,
    OP_NEXT_KEY = 3'd2,
    OP_ADJUST   = 3'd3,
    OP_DELETE   = 3'd4
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK             = 3'd0,
    ST_INVALID        = 3'd1,
    ST_OUT_OF_RANGE   = 3'd2,
    ST_ALREADY_EXISTS = 3'd3,
    ST_NO_NEXT_KEY    = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_LOOKUP,
    S_ADJUST
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic clr_wr;
    logic cnt_inc;
    logic cnt_clr;
    logic capture;
    logic quick_load;
    logic upd_wr;
    logic lookup_load;
    logic adj_run;
    logic adj_load;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clr_last;
    logic lookup_hit;
    logic is_adjust;
    logic upd_ok;
    logic adj_done;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

@@ hw/rtl/offset_table_with_shift_adjust.sv @@
// Table of SLOT_COUNT 32-bit instruction offsets held in one RAM, with the
// first entries_in_use slots live (a larger setting counts as SLOT_COUNT).
// After reset a clearing pass writes zero to all SLOT_COUNT slots, one per
// cycle, and no input word is accepted during the pass; configuration writes
// are taken at any time, but should only be issued while the block is idle.
// One item is processed at a time. An in-range lookup goes from decode to a
// lookup state that loads the word read from the table; update, next key,
// delete, unused codes and out-of-range lookups load their result from decode;
// adjust walks the live slots through the single read and write port of the
// table, one slot per cycle, and then drains the last write-back before its
// result is loaded. The next word can be accepted in the cycle after the
// result is loaded. Results sit in an output register, so the next word is
// accepted while a result waits for the downstream side; a stalled output
// only delays the loading of the following result.
`default_nettype none

module offset_table_with_shift_adjust #(
  parameter int unsigned SLOT_COUNT = 64
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [otsa_pkg::CFG_W-1:0]    cfg_entries_in_use_i,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [otsa_pkg::OP_W-1:0]     operation_i,
  input  wire logic [otsa_pkg::WORD_W-1:0]   index_i,
  input  wire logic                          key_present_i,
  input  wire logic [otsa_pkg::WORD_W-1:0]   new_value_i,
  input  wire logic [otsa_pkg::FLAG_W-1:0]   update_flags_i,
  input  wire logic [otsa_pkg::WORD_W-1:0]   shift_point_i,
  input  wire logic [otsa_pkg::WORD_W-1:0]   patch_length_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic      [otsa_pkg::ST_W-1:0]     status_o,
  output logic      [otsa_pkg::WORD_W-1:0]   data_o
);

  otsa_pkg::ctrl_cmd_t cmd;
  otsa_pkg::dp_stat_t  stat;

  assign cfg_ready_o = 1'b1;

  otsa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  otsa_dp #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_dp (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_i                (cmd),
    .stat_o               (stat),
    .cfg_valid_i          (cfg_valid_i),
    .cfg_entries_in_use_i (cfg_entries_in_use_i),
    .operation_i          (operation_i),
    .index_i              (index_i),
    .key_present_i        (key_present_i),
    .new_value_i          (new_value_i),
    .update_flags_i       (update_flags_i),
    .shift_point_i        (shift_point_i),
    .patch_length_i       (patch_length_i),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .status_o             (status_o),
    .data_o               (data_o)
  );

endmodule

`default_nettype wire

@@ hw/rtl/otsa_ram.sv @@
`default_nettype none

module otsa_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                   clk_i,
  input  wire logic                   wr_en_i,
  input  wire logic [AddrW-1:0]       wr_addr_i,
  input  wire logic [WIDTH-1:0]       wr_data_i,
  input  wire logic [AddrW-1:0]       rd_addr_i,
  output logic      [WIDTH-1:0]       rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

@@ hw/rtl/otsa_ctrl.sv @@
`default_nettype none

module otsa_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire otsa_pkg::dp_stat_t stat_i,
  output otsa_pkg::ctrl_cmd_t     cmd_o
);

  otsa_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= otsa_pkg::S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      otsa_pkg::S_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (stat_i.clr_last) begin
          cmd_o.cnt_clr = 1'b1;
          state_d       = otsa_pkg::S_IDLE;
        end else begin
          cmd_o.cnt_inc = 1'b1;
        end
      end
      otsa_pkg::S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = otsa_pkg::S_DECODE;
        end
      end
      otsa_pkg::S_DECODE: begin
        if (stat_i.lookup_hit) begin
          state_d = otsa_pkg::S_LOOKUP;
        end else if (stat_i.is_adjust) begin
          cmd_o.cnt_clr = 1'b1;
          state_d       = otsa_pkg::S_ADJUST;
        end else if (stat_i.out_free) begin
          cmd_o.quick_load = 1'b1;
          cmd_o.upd_wr     = stat_i.upd_ok;
          state_d          = otsa_pkg::S_IDLE;
        end
      end
      otsa_pkg::S_LOOKUP: begin
        if (stat_i.out_free) begin
          cmd_o.lookup_load = 1'b1;
          state_d           = otsa_pkg::S_IDLE;
        end
      end
      otsa_pkg::S_ADJUST: begin
        cmd_o.adj_run = 1'b1;
        if (stat_i.adj_done && stat_i.out_free) begin
          cmd_o.adj_load = 1'b1;
          state_d        = otsa_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = otsa_pkg::S_IDLE;
      end
    endcase
  end

  a_accept_to_decode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == otsa_pkg::S_DECODE))
    else $error("accepted word did not reach decode");

  a_clear_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == otsa_pkg::S_CLEAR && !stat_i.clr_last) |=> (state_q == otsa_pkg::S_CLEAR))
    else $error("clearing pass left early");

  a_update_write_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.upd_wr |=> (state_q == otsa_pkg::S_IDLE))
    else $error("update write not followed by idle");

endmodule

`default_nettype wire

@@ hw/rtl/otsa_dp.sv @@
`default_nettype none

module otsa_dp #(
  parameter int unsigned SLOT_COUNT = 64
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire otsa_pkg::ctrl_cmd_t               cmd_i,
  output otsa_pkg::dp_stat_t                     stat_o,
  input  wire logic                              cfg_valid_i,
  input  wire logic [otsa_pkg::CFG_W-1:0]        cfg_entries_in_use_i,
  input  wire logic [otsa_pkg::OP_W-1:0]         operation_i,
  input  wire logic [otsa_pkg::WORD_W-1:0]       index_i,
  input  wire logic                              key_present_i,
  input  wire logic [otsa_pkg::WORD_W-1:0]       new_value_i,
  input  wire logic [otsa_pkg::FLAG_W-1:0]       update_flags_i,
  input  wire logic [otsa_pkg::WORD_W-1:0]       shift_point_i,
  input  wire logic [otsa_pkg::WORD_W-1:0]       patch_length_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic      [otsa_pkg::ST_W-1:0]         status_o,
  output logic      [otsa_pkg::WORD_W-1:0]       data_o
);

  localparam int unsigned AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int unsigned CW = $clog2(SLOT_COUNT + 1);
  localparam int unsigned WW = otsa_pkg::WORD_W;

  // Config register
  logic [otsa_pkg::CFG_W-1:0] entries_q;
  logic [CW-1:0]              live;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entries_q <= otsa_pkg::ENTRIES_RESET;
    end else if (cfg_valid_i) begin
      entries_q <= cfg_entries_in_use_i;
    end
  end

  // Saturate at table depth
  assign live = (WW'(entries_q) > WW'(SLOT_COUNT)) ? CW'(SLOT_COUNT) : CW'(entries_q);

  // Item registers
  logic [otsa_pkg::OP_W-1:0]   op_q;
  logic [WW-1:0]               index_q;
  logic                        key_present_q;
  logic [WW-1:0]               new_value_q;
  logic [otsa_pkg::FLAG_W-1:0] flags_q;
  logic [WW-1:0]               shift_point_q;
  logic [WW-1:0]               diff_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q          <= operation_i;
      index_q       <= index_i;
      key_present_q <= key_present_i;
      new_value_q   <= new_value_i;
      flags_q       <= update_flags_i;
      shift_point_q <= shift_point_i;
      diff_q        <= patch_length_i - WW'(1);
    end
  end

  // Slot counter for clearing and adjust
  logic [CW-1:0] cnt_q;
  logic          cnt_in_live;
  logic          adj_rd;

  assign cnt_in_live = (cnt_q < live);
  assign adj_rd      = cmd_i.adj_run && cnt_in_live;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.cnt_clr) begin
      cnt_q <= '0;
    end else if (cmd_i.cnt_inc || adj_rd) begin
      cnt_q <= cnt_q + CW'(1);
    end
  end

  // Adjust read-modify-write: read slot cnt, write back the slot read last cycle if it lies above the shift point
  logic          adj_pend_q;
  logic [AW-1:0] adj_addr_q;
  logic [WW-1:0] rd_data;
  logic          adj_wr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      adj_pend_q <= 1'b0;
    end else begin
      adj_pend_q <= adj_rd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adj_rd) begin
      adj_addr_q <= cnt_q[AW-1:0];
    end
  end

  assign adj_wr = adj_pend_q && (rd_data > shift_point_q);

  // Table port muxing
  logic          ram_we;
  logic [AW-1:0] ram_wa;
  logic [WW-1:0] ram_wd;
  logic [AW-1:0] ram_ra;

  always_comb begin
    ram_we = 1'b0;
    ram_wa = index_q[AW-1:0];
    ram_wd = new_value_q;
    if (cmd_i.clr_wr) begin
      ram_we = 1'b1;
      ram_wa = cnt_q[AW-1:0];
      ram_wd = '0;
    end else if (cmd_i.upd_wr) begin
      ram_we = 1'b1;
    end else if (adj_wr) begin
      ram_we = 1'b1;
      ram_wa = adj_addr_q;
      ram_wd = rd_data + diff_q;
    end
  end

  assign ram_ra = cmd_i.adj_run ? cnt_q[AW-1:0] : index_q[AW-1:0];

  otsa_ram #(
    .WIDTH (WW),
    .DEPTH (SLOT_COUNT)
  ) u_table (
    .clk_i     (clk_i),
    .wr_en_i   (ram_we),
    .wr_addr_i (ram_wa),
    .wr_data_i (ram_wd),
    .rd_addr_i (ram_ra),
    .rd_data_o (rd_data)
  );

  // Results that need no table read
  logic                      in_range;
  logic [WW-1:0]             key_v;
  logic [otsa_pkg::ST_W-1:0] quick_status;
  logic [WW-1:0]             quick_data;
  logic                      upd_ok;

  assign in_range = (index_q < WW'(live));
  assign key_v    = key_present_q ? index_q : '1;

  always_comb begin
    quick_status = otsa_pkg::ST_INVALID;
    quick_data   = '0;
    upd_ok       = 1'b0;
    unique case (op_q)
      otsa_pkg::OP_LOOKUP: begin
        quick_status = otsa_pkg::ST_OUT_OF_RANGE;
      end
      otsa_pkg::OP_UPDATE: begin
        if (flags_q[otsa_pkg::FLAG_NOEXIST] && flags_q[otsa_pkg::FLAG_EXIST]) begin
          quick_status = otsa_pkg::ST_INVALID;
        end else if (!in_range) begin
          quick_status = otsa_pkg::ST_OUT_OF_RANGE;
        end else if (flags_q[otsa_pkg::FLAG_NOEXIST]) begin
          quick_status = otsa_pkg::ST_ALREADY_EXISTS;
        end else begin
          quick_status = otsa_pkg::ST_OK;
          upd_ok       = 1'b1;
        end
      end
      otsa_pkg::OP_NEXT_KEY: begin
        if (key_v >= WW'(live)) begin
          quick_status = otsa_pkg::ST_OK;
        end else if (key_v == (WW'(live) - WW'(1))) begin
          quick_status = otsa_pkg::ST_NO_NEXT_KEY;
        end else begin
          quick_status = otsa_pkg::ST_OK;
          quick_data   = key_v + WW'(1);
        end
      end
      otsa_pkg::OP_ADJUST: begin
        quick_status = otsa_pkg::ST_OK;
      end
      default: begin
        quick_status = otsa_pkg::ST_INVALID;
      end
    endcase
  end

  // Output register
  logic                      out_valid_q;
  logic [otsa_pkg::ST_W-1:0] out_status_q;
  logic [WW-1:0]             out_data_q;
  logic                      out_free;
  logic                      res_load;

  assign out_free = !out_valid_q || !out_stall_i;
  assign res_load = cmd_i.quick_load || cmd_i.lookup_load || cmd_i.adj_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.quick_load) begin
      out_status_q <= quick_status;
      out_data_q   <= quick_data;
    end else if (cmd_i.lookup_load) begin
      out_status_q <= otsa_pkg::ST_OK;
      out_data_q   <= rd_data;
    end else if (cmd_i.adj_load) begin
      out_status_q <= otsa_pkg::ST_OK;
      out_data_q   <= '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign data_o      = out_data_q;

  // Status to controller
  always_comb begin
    stat_o            = '0;
    stat_o.clr_last   = (cnt_q == CW'(SLOT_COUNT - 1));
    stat_o.lookup_hit = (op_q == otsa_pkg::OP_LOOKUP) && in_range;
    stat_o.is_adjust  = (op_q == otsa_pkg::OP_ADJUST);
    stat_o.upd_ok     = upd_ok;
    stat_o.adj_done   = !cnt_in_live && !adj_pend_q;
    stat_o.out_free   = out_free;
  end

  a_one_writer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_i.clr_wr, cmd_i.upd_wr, adj_wr}))
    else $error("table write port driven by two sources");

  a_adj_addr_trails: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adj_pend_q |-> ((CW'(adj_addr_q) + CW'(1)) == cnt_q))
    else $error("adjust write-back address out of step with counter");

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load |-> (out_free &&
                  $onehot({cmd_i.quick_load, cmd_i.lookup_load, cmd_i.adj_load})))
    else $error("result loaded into busy output register");

endmodule

`default_nettype wire

@@ test/tb_offset_table_with_shift_adjust.sv @@
`timescale 1ns / 1ps

module tb_offset_table_with_shift_adjust;

  localparam int unsigned OP_W   = otsa_pkg::OP_W;
  localparam int unsigned WORD_W = otsa_pkg::WORD_W;
  localparam int unsigned FLAG_W = otsa_pkg::FLAG_W;
  localparam int unsigned ST_W   = otsa_pkg::ST_W;
  localparam int unsigned CFG_W  = otsa_pkg::CFG_W;

  localparam int unsigned TABLE_DEPTH = 64;
  localparam int unsigned WORDS_PER_SESSION = 150;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned TAIL_CYCLES = 80;
  localparam int unsigned HANG_LIMIT = 4000;
  localparam int unsigned MAX_PRINTED = 40;

  localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_LAST  = 3'd7;
  localparam logic [OP_W-1:0] OP_ALL_ONES    = '1;

  localparam logic [FLAG_W-1:0] FL_NONE    = '0;
  localparam logic [FLAG_W-1:0] FL_NOEXIST = FLAG_W'(1 << otsa_pkg::FLAG_NOEXIST);
  localparam logic [FLAG_W-1:0] FL_EXIST   = FLAG_W'(1 << otsa_pkg::FLAG_EXIST);
  localparam logic [FLAG_W-1:0] FL_LOCK    = 3'b100;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [WORD_W-1:0] index;
    logic              key_present;
    logic [WORD_W-1:0] new_value;
    logic [FLAG_W-1:0] flags;
    logic [WORD_W-1:0] shift_point;
    logic [WORD_W-1:0] patch_length;
  } request_t;

  typedef struct packed {
    logic [ST_W-1:0]   status;
    logic [WORD_W-1:0] data;
  } offset_reply_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [CFG_W-1:0]  cfg_entries_in_use_i = '0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [OP_W-1:0]   operation_i = '0;
  logic [WORD_W-1:0] index_i = '0;
  logic              key_present_i = 1'b0;
  logic [WORD_W-1:0] new_value_i = '0;
  logic [FLAG_W-1:0] update_flags_i = '0;
  logic [WORD_W-1:0] shift_point_i = '0;
  logic [WORD_W-1:0] patch_length_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [ST_W-1:0]   status_o;
  logic [WORD_W-1:0] data_o;

  // Predicted block state
  logic [WORD_W-1:0] offsets_model [TABLE_DEPTH];
  logic [CFG_W-1:0]  live_cfg = otsa_pkg::ENTRIES_RESET;

  offset_reply_t pending_replies[$];
  int unsigned   words_sent = 0;
  int unsigned   replies_checked = 0;
  int unsigned   mismatches = 0;
  int unsigned   sizes_run = 0;
  int unsigned   quiet_cycles = 0;
  int unsigned   stall_left = 0;
  bit            idle_on = 1'b1;

  offset_table_with_shift_adjust #(
    .SLOT_COUNT(TABLE_DEPTH)
  ) dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_entries_in_use_i(cfg_entries_in_use_i),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .operation_i         (operation_i),
    .index_i             (index_i),
    .key_present_i       (key_present_i),
    .new_value_i         (new_value_i),
    .update_flags_i      (update_flags_i),
    .shift_point_i       (shift_point_i),
    .patch_length_i      (patch_length_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .status_o            (status_o),
    .data_o              (data_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  initial begin
    foreach (offsets_model[i]) offsets_model[i] = '0;
  end

  function automatic int unsigned live_slots();
    return (live_cfg > TABLE_DEPTH) ? TABLE_DEPTH : live_cfg;
  endfunction

  // Apply one word to the table model and return what the block should answer
  function automatic offset_reply_t predict_reply(request_t rq);
    offset_reply_t r;
    int unsigned n;
    logic [WORD_W-1:0] key;
    logic [WORD_W-1:0] shift;
    n = live_slots();
    r.status = otsa_pkg::ST_INVALID;
    r.data = '0;
    case (rq.op)
      otsa_pkg::OP_LOOKUP: begin
        if (rq.index < n) begin
          r.status = otsa_pkg::ST_OK;
          r.data = offsets_model[rq.index];
        end else begin
          r.status = otsa_pkg::ST_OUT_OF_RANGE;
        end
      end
      otsa_pkg::OP_UPDATE: begin
        if (rq.flags[otsa_pkg::FLAG_NOEXIST] && rq.flags[otsa_pkg::FLAG_EXIST]) begin
          r.status = otsa_pkg::ST_INVALID;
        end else if (rq.index >= n) begin
          r.status = otsa_pkg::ST_OUT_OF_RANGE;
        end else if (rq.flags[otsa_pkg::FLAG_NOEXIST]) begin
          r.status = otsa_pkg::ST_ALREADY_EXISTS;
        end else begin
          offsets_model[rq.index] = rq.new_value;
          r.status = otsa_pkg::ST_OK;
        end
      end
      otsa_pkg::OP_NEXT_KEY: begin
        key = rq.key_present ? rq.index : '1;
        if (key >= n) begin
          r.status = otsa_pkg::ST_OK;
        end else if (key == n - 1) begin
          r.status = otsa_pkg::ST_NO_NEXT_KEY;
        end else begin
          r.status = otsa_pkg::ST_OK;
          r.data = key + 1;
        end
      end
      otsa_pkg::OP_ADJUST: begin
        shift = rq.patch_length - 1;
        if (shift != '0) begin
          for (int unsigned i = 0; i < n; i++) begin
            if (offsets_model[i] > rq.shift_point) offsets_model[i] += shift;
          end
        end
        r.status = otsa_pkg::ST_OK;
      end
      default: r.status = otsa_pkg::ST_INVALID;
    endcase
    return r;
  endfunction

  function automatic request_t noise_request();
    request_t r;
    r.op = OP_W'($urandom);
    r.index = $urandom;
    r.key_present = 1'($urandom);
    r.new_value = $urandom;
    r.flags = FLAG_W'($urandom);
    r.shift_point = $urandom;
    r.patch_length = $urandom;
    return r;
  endfunction

  function automatic request_t make_req(logic [OP_W-1:0] op, logic [WORD_W-1:0] index);
    request_t r;
    r = noise_request();
    r.op = op;
    r.index = index;
    return r;
  endfunction

  function automatic request_t update_req(logic [WORD_W-1:0] index, logic [WORD_W-1:0] value,
                                          logic [FLAG_W-1:0] flags);
    request_t r;
    r = make_req(otsa_pkg::OP_UPDATE, index);
    r.new_value = value;
    r.flags = flags;
    return r;
  endfunction

  function automatic request_t next_req(logic present, logic [WORD_W-1:0] index);
    request_t r;
    r = make_req(otsa_pkg::OP_NEXT_KEY, index);
    r.key_present = present;
    return r;
  endfunction

  function automatic request_t adjust_req(logic [WORD_W-1:0] point, logic [WORD_W-1:0] len);
    request_t r;
    r = make_req(otsa_pkg::OP_ADJUST, $urandom);
    r.shift_point = point;
    r.patch_length = len;
    return r;
  endfunction

  // Mostly well-formed words aimed at the live slots, with some full-range noise
  function automatic request_t random_request(int unsigned n);
    request_t r;
    int unsigned pick;
    r = noise_request();
    pick = $urandom_range(0, 99);
    if (pick < 25) r.op = otsa_pkg::OP_LOOKUP;
    else if (pick < 55) r.op = otsa_pkg::OP_UPDATE;
    else if (pick < 70) r.op = otsa_pkg::OP_NEXT_KEY;
    else if (pick < 82) r.op = otsa_pkg::OP_ADJUST;
    else if (pick < 88) r.op = otsa_pkg::OP_DELETE;
    else if (pick < 94) r.op = OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
    else r.op = OP_W'($urandom_range(0, OP_ALL_ONES));
    if ($urandom_range(0, 99) < 85) r.index = $urandom_range(0, n + 1);
    if (r.op == otsa_pkg::OP_UPDATE && $urandom_range(0, 99) < 75)
      r.flags = r.flags & ~FL_NOEXIST;
    case ($urandom_range(0, 3))
      0, 1: r.new_value = $urandom_range(0, 1023);
      2: r.new_value = '1 - $urandom_range(0, 1023);
      default: ;
    endcase
    pick = $urandom_range(0, 2);
    if (pick == 0 && n > 0) r.shift_point = offsets_model[$urandom_range(0, n - 1)] -
                                            $urandom_range(0, 1);
    else if (pick == 1) r.shift_point = $urandom_range(0, 1023);
    pick = $urandom_range(0, 99);
    if (pick < 40) r.patch_length = $urandom_range(0, 8);
    else if (pick < 55) r.patch_length = 1;
    r.key_present = ($urandom_range(0, 4) != 0);
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_PRINTED) $display("%0t mismatch: %s", $realtime, what);
  endtask

  // Call at a falling edge; returns at the falling edge after the word is taken
  task automatic send_word(input request_t rq);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk_i);
    end
    operation_i <= rq.op;
    index_i <= rq.index;
    key_present_i <= rq.key_present;
    new_value_i <= rq.new_value;
    update_flags_i <= rq.flags;
    shift_point_i <= rq.shift_point;
    patch_length_i <= rq.patch_length;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    pending_replies.push_back(predict_reply(rq));
    words_sent++;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_replies.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_live_count(input logic [CFG_W-1:0] value);
    wait_drained();
    cfg_entries_in_use_i <= value;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    live_cfg = value;
    sizes_run++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic test_lookup_after_reset();
    send_word(make_req(otsa_pkg::OP_LOOKUP, 0));
    send_word(make_req(otsa_pkg::OP_LOOKUP, TABLE_DEPTH - 1));
    send_word(make_req(otsa_pkg::OP_LOOKUP, TABLE_DEPTH));
    send_word(make_req(otsa_pkg::OP_LOOKUP, '1));
  endtask

  task automatic test_update_rules();
    send_word(update_req(0, '1, FL_NONE));
    send_word(update_req(TABLE_DEPTH - 1, 32'h8000_0000, FL_EXIST));
    send_word(update_req(5, 32'd100, FL_LOCK));
    // bad flags win over the index check
    send_word(update_req(0, 32'd7, FL_NOEXIST | FL_EXIST));
    send_word(update_req('1, 32'd7, FL_NOEXIST | FL_EXIST | FL_LOCK));
    send_word(update_req(5, 32'd9, FL_NOEXIST));
    send_word(update_req(TABLE_DEPTH, 32'd9, FL_NOEXIST | FL_LOCK));
    send_word(update_req('1, 32'd9, FL_NONE));
  endtask

  task automatic test_next_key_walk();
    send_word(next_req(1'b0, 0));
    send_word(next_req(1'b1, 0));
    send_word(next_req(1'b1, TABLE_DEPTH - 2));
    send_word(next_req(1'b1, TABLE_DEPTH - 1));
    send_word(next_req(1'b1, TABLE_DEPTH));
    send_word(next_req(1'b1, '1));
  endtask

  task automatic test_adjust_shift();
    send_word(adjust_req(0, 32'd1));
    // zero length shifts back by one
    send_word(adjust_req(32'd99, 32'd0));
    send_word(adjust_req('1, 32'd5));
    send_word(adjust_req(0, '1));
    send_word(make_req(otsa_pkg::OP_LOOKUP, 0));
    send_word(make_req(otsa_pkg::OP_LOOKUP, 5));
    send_word(make_req(otsa_pkg::OP_LOOKUP, TABLE_DEPTH - 1));
  endtask

  task automatic test_refused_ops();
    send_word(make_req(otsa_pkg::OP_DELETE, 0));
    send_word(make_req(otsa_pkg::OP_DELETE, '1));
    for (int c = OP_SPARE_FIRST; c <= OP_SPARE_LAST; c++) send_word(make_req(OP_W'(c), 0));
  endtask

  task automatic test_random_sessions();
    logic [CFG_W-1:0] sizes[$];
    sizes = '{otsa_pkg::ENTRIES_RESET, 7'd1, 7'd0, 7'd127, 7'd2,
              CFG_W'($urandom_range(3, 62)), CFG_W'($urandom_range(65, 126)), 7'd63,
              otsa_pkg::ENTRIES_RESET};
    foreach (sizes[p]) begin
      idle_on = (p != sizes.size() - 1) && (p % 3 != 2);
      write_live_count(sizes[p]);
      repeat (WORDS_PER_SESSION) send_word(random_request(live_slots()));
    end
  endtask

  // Receiver stalls in random bursts
  always @(negedge clk_i) begin
    if (stall_left > 0) stall_left--;
    else if (idle_on && $urandom_range(0, 4) == 0) stall_left = $urandom_range(1, 5);
    out_stall_i <= (stall_left > 0);
  end

  always @(posedge clk_i) begin : check_replies
    offset_reply_t want;
    if (rst_ni && out_valid_o === 1'b1 && !out_stall_i) begin
      replies_checked++;
      if (pending_replies.size() == 0) begin
        report_mismatch($sformatf("unexpected result status %0d data %h", status_o, data_o));
      end else begin
        want = pending_replies.pop_front();
        if (status_o !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", status_o, want.status));
        if (data_o !== want.data)
          report_mismatch($sformatf("data %h, want %h", data_o, want.data));
      end
    end
  end

  // Hang detection: no handshake of any kind for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && in_stall_o === 1'b0) || (out_valid_o === 1'b1 && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o === 1'b1))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= HANG_LIMIT) begin
      $display("timeout: %0d results still pending", pending_replies.size());
      $display("tb_offset_table_with_shift_adjust NOT OK");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_lookup_after_reset();
    test_update_rules();
    test_next_key_walk();
    test_adjust_shift();
    test_refused_ops();
    test_random_sessions();
    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk_i);
    $display("sent %0d words over %0d live-count settings (0, 1, 2, 63, 64, 127, others)",
             words_sent, sizes_run);
    $display("checked %0d results, %0d mismatches", replies_checked, mismatches);
    if (mismatches == 0 && pending_replies.size() == 0)
      $display("tb_offset_table_with_shift_adjust OK");
    else
      $display("tb_offset_table_with_shift_adjust NOT OK");
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/otsa_pkg.sv
hw/rtl/otsa_ram.sv
hw/rtl/otsa_ctrl.sv
hw/rtl/otsa_dp.sv
hw/rtl/offset_table_with_shift_adjust.sv
test/tb_offset_table_with_shift_adjust.sv
